FILE: rtl/core/udrmq_pkg.sv
package udrmq_pkg;

    // Table and queue sizing
    localparam int MAX_RULES   = 64;
    localparam int QUEUE_DEPTH = 256;
    localparam int RI_W        = $clog2(MAX_RULES);
    localparam int RC_W        = $clog2(MAX_RULES + 1);
    localparam int QA_W        = $clog2(QUEUE_DEPTH);
    localparam int PTR_W       = 8;
    localparam int FILL_W      = 9;

    // Queue size register limits
    localparam int QSIZE_W   = 9;
    localparam int QSIZE_MIN = 8;
    localparam int QSIZE_MAX = 256;
    localparam int QSIZE_RST = (32 > QUEUE_DEPTH) ? QUEUE_DEPTH : 32;

    // Result field widths
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int ENTRY_W  = 6;
    localparam int COUNT_SAT = 127;

    localparam int MODE_W     = 3;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [MODE_W-1:0] {
        OP_APPEND     = 3'd0,
        OP_ACTIVATE   = 3'd1,
        OP_DEACTIVATE = 3'd2,
        OP_PROBE      = 3'd3,
        OP_POP        = 3'd4,
        OP_CLEAR      = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_NOCAT = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // Input beat payload, last field in the lowest bits
    typedef struct packed {
        logic        pad;
        logic        start_active;
        logic [7:0]  category_id;
        logic [5:0]  wildcard_mask;
        logic [7:0]  protocol_code;
        logic [7:0]  subclass_code;
        logic [7:0]  class_code;
        logic [15:0] release_code;
        logic [15:0] product_id;
        logic [15:0] vendor_id;
    } in_item_t;

    // Output beat payload, last field in the lowest bits
    typedef struct packed {
        logic               load_event;
        logic [ENTRY_W-1:0] entry_index;
        logic [COUNT_W-1:0] match_count;
        status_t            status;
    } out_item_t;

    // One stored rule, without its active flag
    typedef struct packed {
        logic [7:0]  category_id;
        logic [5:0]  wildcard_mask;
        logic [15:0] vendor_id;
        logic [15:0] product_id;
        logic [15:0] release_code;
        logic [7:0]  class_code;
        logic [7:0]  subclass_code;
        logic [7:0]  protocol_code;
    } rule_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic dispatch;
        logic walk;
        logic load_out;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic walk_mode;
        logic walk_more;
        logic out_free;
    } ctrl_sts_t;

endpackage

FILE: rtl/core/udrmq_ram.sv
module udrmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/udrmq_ctrl.sv
module udrmq_ctrl
    import udrmq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DISPATCH,
        S_WALK,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cmd.dispatch = 1'b1;
                state_next   = sts.walk_mode ? S_WALK : S_RESULT;
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (!sts.walk_more)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        in_ready_next = (state_next == S_IDLE);
    end

    // Hold state and the input ready flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= in_ready_next;
        end
    end

    assign in_ready = in_ready_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready_reg |-> state_reg == S_IDLE)
        else $error("input ready outside idle");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && !sts.out_free) |=> state_reg == S_RESULT)
        else $error("result dropped while output busy");

endmodule

FILE: rtl/core/udrmq_dp.sv
module udrmq_dp
    import udrmq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [QSIZE_W-1:0]    cfg_data,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  logic [MODE_W-1:0]     in_mode,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data,
    input  ctrl_cmd_t             cmd,
    output ctrl_sts_t             sts
);

    localparam logic [RC_W-1:0] RULES_FULL = RC_W'(MAX_RULES);

    // Captured item
    in_item_t          item_reg;
    logic [MODE_W-1:0] mode_reg;

    // Table and queue control state
    logic [RC_W-1:0]    rule_count_reg;
    logic [PTR_W-1:0]   rptr_reg;
    logic [PTR_W-1:0]   wptr_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [QSIZE_W-1:0] qsize_reg;
    logic [RC_W-1:0]    walk_idx_reg;
    logic               rd_vld_reg;
    logic [RI_W-1:0]    rd_idx_reg;
    logic [RC_W-1:0]    count_reg;
    logic               flag_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;

    logic [PTR_W-1:0]   rptr_next;
    logic [PTR_W-1:0]   wptr_next;
    logic [FILL_W-1:0]  fill_next;
    logic [QSIZE_W-1:0] qsize_next;
    logic [PTR_W-1:0]   rptr_inc;
    logic [PTR_W-1:0]   wptr_inc;
    out_item_t          out_next;

    logic  is_cat;
    logic  is_probe;
    logic  walk_more;
    logic  table_full;
    logic  append_we;
    logic  walk_re;
    logic  cat_hit;
    logic  match;
    logic  push;
    logic  pop;
    logic  do_clear;
    rule_t rule_wdata;
    rule_t rule_q;
    logic  act_q;
    logic  act_we;
    logic  act_wdata;
    logic [RI_W-1:0]    act_waddr;
    logic [ENTRY_W-1:0] q_rdata;

    assign is_cat     = (mode_reg == OP_ACTIVATE) || (mode_reg == OP_DEACTIVATE);
    assign is_probe   = (mode_reg == OP_PROBE);
    assign walk_more  = (walk_idx_reg < rule_count_reg);
    assign table_full = (rule_count_reg >= RULES_FULL);
    assign append_we  = cmd.dispatch && (mode_reg == OP_APPEND) && !table_full;
    assign walk_re    = cmd.walk && walk_more;
    assign pop        = cmd.dispatch && (mode_reg == OP_POP) && (fill_reg != '0);
    assign do_clear   = cmd.dispatch && (mode_reg == OP_CLEAR);

    // Build the rule from the captured item
    always_comb
    begin
        rule_wdata.category_id   = item_reg.category_id;
        rule_wdata.wildcard_mask = item_reg.wildcard_mask;
        rule_wdata.vendor_id     = item_reg.vendor_id;
        rule_wdata.product_id    = item_reg.product_id;
        rule_wdata.release_code  = item_reg.release_code;
        rule_wdata.class_code    = item_reg.class_code;
        rule_wdata.subclass_code = item_reg.subclass_code;
        rule_wdata.protocol_code = item_reg.protocol_code;
    end

    udrmq_ram #(
        .WIDTH ($bits(rule_t)),
        .DEPTH (MAX_RULES)
    ) u_rule_ram (
        .clk   (clk),
        .we    (append_we),
        .waddr (rule_count_reg[RI_W-1:0]),
        .wdata (rule_wdata),
        .re    (walk_re),
        .raddr (walk_idx_reg[RI_W-1:0]),
        .rdata (rule_q)
    );

    // Evaluate the rule that came back from the table
    assign cat_hit = rd_vld_reg && is_cat && (rule_q.category_id == item_reg.category_id);
    assign match   = rd_vld_reg && is_probe && act_q
        && (rule_q.wildcard_mask[0] || rule_q.vendor_id     == item_reg.vendor_id)
        && (rule_q.wildcard_mask[1] || rule_q.product_id    == item_reg.product_id)
        && (rule_q.wildcard_mask[2] || rule_q.release_code  == item_reg.release_code)
        && (rule_q.wildcard_mask[3] || rule_q.class_code    == item_reg.class_code)
        && (rule_q.wildcard_mask[4] || rule_q.subclass_code == item_reg.subclass_code)
        && (rule_q.wildcard_mask[5] || rule_q.protocol_code == item_reg.protocol_code);
    assign push    = match && (fill_reg < FILL_W'(qsize_reg));

    // Active flags: written on append, rewritten by the category walk
    assign act_we    = append_we || cat_hit;
    assign act_waddr = append_we ? rule_count_reg[RI_W-1:0] : rd_idx_reg;
    assign act_wdata = append_we ? item_reg.start_active : (mode_reg == OP_ACTIVATE);

    udrmq_ram #(
        .WIDTH (1),
        .DEPTH (MAX_RULES)
    ) u_active_ram (
        .clk   (clk),
        .we    (act_we),
        .waddr (act_waddr),
        .wdata (act_wdata),
        .re    (walk_re),
        .raddr (walk_idx_reg[RI_W-1:0]),
        .rdata (act_q)
    );

    udrmq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (push),
        .waddr (QA_W'(wptr_reg)),
        .wdata (ENTRY_W'(rd_idx_reg)),
        .re    (pop),
        .raddr (QA_W'(rptr_reg)),
        .rdata (q_rdata)
    );

    // Advance queue pointers, wrap at the queue size
    always_comb
    begin
        wptr_inc  = wptr_reg + 1'b1;
        rptr_inc  = rptr_reg + 1'b1;
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        fill_next = fill_reg;
        if (push)
        begin
            wptr_next = ({1'b0, wptr_inc} >= qsize_reg) ? '0 : wptr_inc;
            fill_next = fill_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = ({1'b0, rptr_inc} >= qsize_reg) ? '0 : rptr_inc;
            fill_next = fill_reg - 1'b1;
        end
        if (do_clear)
        begin
            fill_next = '0;
        end
    end

    // Clamp the written queue size
    always_comb
    begin
        qsize_next = qsize_reg;
        if (cfg_valid)
        begin
            qsize_next = cfg_data;
            if (qsize_next > QSIZE_W'(QSIZE_MAX))
            begin
                qsize_next = QSIZE_W'(QSIZE_MAX);
            end
            if (qsize_next < QSIZE_W'(QSIZE_MIN))
            begin
                qsize_next = QSIZE_W'(QSIZE_MIN);
            end
            if (qsize_next > QSIZE_W'(QUEUE_DEPTH))
            begin
                qsize_next = QSIZE_W'(QUEUE_DEPTH);
            end
        end
    end

    // Form the result beat
    always_comb
    begin
        out_next.status      = ST_OK;
        out_next.entry_index = '0;
        out_next.load_event  = is_probe && (count_reg != '0);
        out_next.match_count = (int'(count_reg) > COUNT_SAT) ? COUNT_W'(COUNT_SAT)
                                                             : COUNT_W'(count_reg);
        case (mode_reg)
            OP_APPEND:
            begin
                out_next.status = flag_reg ? ST_FULL : ST_OK;
            end
            OP_ACTIVATE, OP_DEACTIVATE:
            begin
                out_next.status = (count_reg == '0) ? ST_NOCAT : ST_OK;
            end
            OP_POP:
            begin
                out_next.status      = flag_reg ? ST_EMPTY : ST_OK;
                out_next.entry_index = flag_reg ? '0 : q_rdata;
            end
            default:
            begin
                out_next.status = ST_OK;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= '0;
            rule_count_reg <= '0;
            rptr_reg       <= '0;
            wptr_reg       <= '0;
            fill_reg       <= '0;
            qsize_reg      <= QSIZE_W'(QSIZE_RST);
            walk_idx_reg   <= '0;
            rd_vld_reg     <= 1'b0;
            count_reg      <= '0;
            flag_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rptr_reg   <= rptr_next;
            wptr_reg   <= wptr_next;
            fill_reg   <= fill_next;
            qsize_reg  <= qsize_next;
            rd_vld_reg <= walk_re;
            if (cmd.capture)
            begin
                mode_reg     <= in_mode;
                walk_idx_reg <= '0;
                count_reg    <= '0;
                flag_reg     <= 1'b0;
            end
            if (append_we)
            begin
                rule_count_reg <= rule_count_reg + 1'b1;
            end
            if (cmd.dispatch && (mode_reg == OP_APPEND) && table_full)
            begin
                flag_reg <= 1'b1;
            end
            if (cmd.dispatch && (mode_reg == OP_POP) && (fill_reg == '0))
            begin
                flag_reg <= 1'b1;
            end
            if (walk_re)
            begin
                walk_idx_reg <= walk_idx_reg + 1'b1;
            end
            if (cat_hit || match)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_item_t'(in_data);
        end
        if (walk_re)
        begin
            rd_idx_reg <= walk_idx_reg[RI_W-1:0];
        end
        if (cmd.load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_reg;
    assign sts.walk_mode = (mode_reg == OP_ACTIVATE) || (mode_reg == OP_DEACTIVATE)
                        || (mode_reg == OP_PROBE);
    assign sts.walk_more = walk_more;
    assign sts.out_free  = !out_valid_reg || out_ready;

    a_rule_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rule_count_reg <= RULES_FULL)
        else $error("rule count past table size");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> fill_reg < FILL_W'(qsize_reg))
        else $error("push into full queue");

    a_pop_fill: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> fill_reg == $past(fill_reg) - 1'b1)
        else $error("pop did not lower fill");

    a_walk_index: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> {1'b0, rd_idx_reg} < rule_count_reg)
        else $error("walk read past rule count");

endmodule

FILE: rtl/core/usb_device_rule_match_queue_unit.sv
// Append, clear, pop and unused modes: capture, dispatch, then the result is registered.
// Activate, deactivate and probe walk the table after dispatch; the walk reads one rule
// per cycle from the single read port of the rule table.
// One item in flight; the next input beat is taken the cycle after the result is
// registered, while that result may still wait for the sink.
// Reset clears rule count, queue pointers and fill, and sets queue size to 32;
// the rule table and queue memories are not cleared and need no clearing pass.
module usb_device_rule_match_queue_unit
    import udrmq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [QSIZE_W-1:0]    cfg_data,    // queue_size
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // vendor_id, product_id, release_code, class_code, subclass_code,
    // protocol_code, wildcard_mask, category_id, start_active, one pad bit
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [MODE_W-1:0]     s_tuser,     // mode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // status, match_count, entry_index, load_event
    output logic [OUT_DATA_W-1:0] m_tdata
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    udrmq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    udrmq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .in_mode   (s_tuser),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

FILE: verif/rule_match_checker.sv
`timescale 1ns / 1ps

module rule_match_checker
    import udrmq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [QSIZE_W-1:0]    cfg_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [MODE_W-1:0]     s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    output int                    fail_count,
    output int                    pending
);

    // Shadow of the rule table and the index ring
    rule_t              rule_table [MAX_RULES];
    logic               rule_on    [MAX_RULES];
    int                 rules_held;
    logic [ENTRY_W-1:0] index_ring [QUEUE_DEPTH];
    int                 ring_rd;
    int                 ring_wr;
    int                 ring_fill;
    int                 ring_size;

    out_item_t          expected_results [$];
    out_item_t          seen_beat;
    out_item_t          due_beat;
    int                 mismatches;
    int                 new_size;

    // Work out the result beat of one input beat and advance the shadow state
    function automatic out_item_t predict_match_result(input logic [MODE_W-1:0] mode,
                                                       input in_item_t d);
        out_item_t  res;
        int         hits;
        rule_t      r;
        logic [5:0] w;
        logic       hit;
        res  = '0;
        hits = 0;
        case (mode)
            OP_APPEND:
            begin
                if (rules_held >= MAX_RULES)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    r.category_id   = d.category_id;
                    r.wildcard_mask = d.wildcard_mask;
                    r.vendor_id     = d.vendor_id;
                    r.product_id    = d.product_id;
                    r.release_code  = d.release_code;
                    r.class_code    = d.class_code;
                    r.subclass_code = d.subclass_code;
                    r.protocol_code = d.protocol_code;
                    rule_table[rules_held] = r;
                    rule_on[rules_held]    = d.start_active;
                    rules_held++;
                end
            end
            OP_ACTIVATE, OP_DEACTIVATE:
            begin
                for (int i = 0; i < rules_held; i++)
                begin
                    if (rule_table[i].category_id == d.category_id)
                    begin
                        rule_on[i] = (mode == OP_ACTIVATE);
                        hits++;
                    end
                end
                if (hits == 0)
                    res.status = ST_NOCAT;
            end
            OP_PROBE:
            begin
                // Walk in table order; count every hit, push only while there is room
                for (int i = 0; i < rules_held; i++)
                begin
                    r   = rule_table[i];
                    w   = r.wildcard_mask;
                    hit = rule_on[i]
                          && (w[0] || r.vendor_id     == d.vendor_id)
                          && (w[1] || r.product_id    == d.product_id)
                          && (w[2] || r.release_code  == d.release_code)
                          && (w[3] || r.class_code    == d.class_code)
                          && (w[4] || r.subclass_code == d.subclass_code)
                          && (w[5] || r.protocol_code == d.protocol_code);
                    if (hit)
                    begin
                        if (ring_fill < ring_size)
                        begin
                            index_ring[ring_wr % QUEUE_DEPTH] = ENTRY_W'(i);
                            ring_wr = (ring_wr + 1) % (1 << PTR_W);
                            if (ring_wr >= ring_size)
                                ring_wr = 0;
                            ring_fill++;
                        end
                        hits++;
                    end
                end
                res.load_event = (hits != 0);
            end
            OP_POP:
            begin
                if (ring_fill == 0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    res.entry_index = index_ring[ring_rd % QUEUE_DEPTH];
                    ring_rd = (ring_rd + 1) % (1 << PTR_W);
                    if (ring_rd >= ring_size)
                        ring_rd = 0;
                    ring_fill--;
                end
            end
            OP_CLEAR:
            begin
                // Only the fill drops; both pointers stay put
                ring_fill = 0;
            end
            default:
            begin
            end
        endcase
        if (hits > COUNT_SAT)
            hits = COUNT_SAT;
        res.match_count = COUNT_W'(hits);
        return res;
    endfunction

    // Track config writes, compare result beats, queue up predictions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rules_held = 0;
            ring_rd    = 0;
            ring_wr    = 0;
            ring_fill  = 0;
            ring_size  = QSIZE_RST;
            mismatches = 0;
            expected_results.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                new_size = int'(cfg_data);
                if (new_size > QSIZE_MAX)
                    new_size = QSIZE_MAX;
                if (new_size < QSIZE_MIN)
                    new_size = QSIZE_MIN;
                if (new_size > QUEUE_DEPTH)
                    new_size = QUEUE_DEPTH;
                ring_size = new_size;
            end

            if (m_tvalid && m_tready)
            begin
                seen_beat = out_item_t'(m_tdata);
                if (expected_results.size() == 0)
                begin
                    $error("result beat %h with no input beat outstanding", m_tdata);
                    mismatches++;
                end
                else
                begin
                    due_beat = expected_results.pop_front();
                    if (seen_beat.status !== due_beat.status)
                    begin
                        $error("status: expected %0d, got %0d",
                               due_beat.status, seen_beat.status);
                        mismatches++;
                    end
                    if (seen_beat.match_count !== due_beat.match_count)
                    begin
                        $error("match_count: expected %0d, got %0d",
                               due_beat.match_count, seen_beat.match_count);
                        mismatches++;
                    end
                    if (seen_beat.entry_index !== due_beat.entry_index)
                    begin
                        $error("entry_index: expected %0d, got %0d",
                               due_beat.entry_index, seen_beat.entry_index);
                        mismatches++;
                    end
                    if (seen_beat.load_event !== due_beat.load_event)
                    begin
                        $error("load_event: expected %0d, got %0d",
                               due_beat.load_event, seen_beat.load_event);
                        mismatches++;
                    end
                end
            end

            if (s_tvalid && s_tready)
                expected_results.push_back(predict_match_result(s_tuser, in_item_t'(s_tdata)));

            fail_count <= mismatches;
            pending    <= expected_results.size();
        end
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import udrmq_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;
    localparam logic [7:0]        SWEEP_CAT      = 8'hEE;
    localparam int                SWEEP_RULES    = 32;
    localparam int                PHASES         = 6;
    localparam int                ITEMS_PER_PHASE = 292;
    localparam int                WATCHDOG_LIMIT = 5000;
    localparam int                SETTLE_CYCLES  = MAX_RULES + 16;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [QSIZE_W-1:0]    cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [MODE_W-1:0]     s_tuser   = '0;
    logic                  m_tready  = 1'b0;
    wire                   cfg_ready;
    wire                   s_tready;
    wire                   m_tvalid;
    wire  [OUT_DATA_W-1:0] m_tdata;

    int       fail_count;
    int       pending;
    int       send_gap_pct   = 0;
    int       sink_stall_pct = 0;
    int       quiet_cycles   = 0;
    in_item_t rule_memory [$];

    usb_device_rule_match_queue_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    rule_match_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Stall the result side at random
    always @(posedge clk)
    begin
        m_tready <= rst_n && ($urandom_range(99) >= sink_stall_pct);
    end

    // Abort when no channel moves a beat for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [15:0] pick_word();
        case ($urandom_range(5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h1D6B;
            3:       return 16'h0403;
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(5))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h03;
            3:       return 8'h09;
            default: return 8'($urandom_range(8'hFF));
        endcase
    endfunction

    // Mostly a handful of categories so that rules share them
    function automatic logic [7:0] pick_category();
        int roll;
        roll = $urandom_range(99);
        if (roll < 85)
            return 8'($urandom_range(7));
        else if (roll < 95)
            return 8'($urandom_range(8'hFF));
        else
            return SWEEP_CAT;
    endfunction

    function automatic in_item_t make_item(input logic [15:0] ven, input logic [15:0] prod,
                                           input logic [15:0] rel_code,
                                           input logic [7:0] cls, input logic [7:0] sub,
                                           input logic [7:0] pro, input logic [5:0] mask,
                                           input logic [7:0] cat, input logic act);
        in_item_t d;
        d               = '0;
        d.vendor_id     = ven;
        d.product_id    = prod;
        d.release_code  = rel_code;
        d.class_code    = cls;
        d.subclass_code = sub;
        d.protocol_code = pro;
        d.wildcard_mask = mask;
        d.category_id   = cat;
        d.start_active  = act;
        return d;
    endfunction

    function automatic in_item_t random_fields();
        return make_item(pick_word(), pick_word(), pick_word(),
                         pick_byte(), pick_byte(), pick_byte(),
                         $urandom_range(1) ? 6'd0 : 6'($urandom_range(63)),
                         pick_category(), 1'($urandom_range(1)));
    endfunction

    // Probe mostly with a stored rule's values, now and then with one field off
    function automatic in_item_t probe_fields();
        in_item_t d;
        d = random_fields();
        if (rule_memory.size() != 0 && $urandom_range(99) < 75)
        begin
            d = rule_memory[$urandom_range(rule_memory.size() - 1)];
            case ($urandom_range(9))
                0: d.vendor_id     = pick_word();
                1: d.product_id    = pick_word();
                2: d.release_code  = pick_word();
                3: d.class_code    = pick_byte();
                4: d.subclass_code = pick_byte();
                5: d.protocol_code = pick_byte();
                default: ;
            endcase
        end
        return d;
    endfunction

    // Offer one beat, with random idle cycles ahead of it
    task automatic send_item(input logic [MODE_W-1:0] mode, input in_item_t d);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= d;
        if (mode == OP_APPEND && rule_memory.size() < MAX_RULES)
            rule_memory.push_back(d);
        do @(posedge clk); while (!s_tready);
    endtask

    // Hold off until every result beat is back, then let the block settle
    task automatic drain(input int settle);
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_queue_size(input logic [QSIZE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        in_item_t              d;
        in_item_t              base;
        logic [MODE_W-1:0]     mode;
        int                    roll;
        logic [QSIZE_W-1:0]    size_plan [PHASES];

        size_plan = '{9'd0, 9'h1FF, 9'd8, 9'd300, 9'd32, 9'd0};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Write every queue slot once: sweeper rules match anything, so a few
        // probes run the write pointer all the way round
        write_queue_size(9'(QSIZE_MAX));
        for (int k = 0; k < SWEEP_RULES; k++)
            send_item(OP_APPEND, make_item(16'hFFFF, 16'h0000, 16'hFFFF, 8'h00, 8'hFF,
                                           8'h00, 6'h3F, SWEEP_CAT, 1'b1));
        rule_memory.delete();
        // The last probe finds the queue full
        for (int k = 0; k <= QUEUE_DEPTH / SWEEP_RULES; k++)
            send_item(OP_PROBE, random_fields());
        send_item(OP_DEACTIVATE, make_item(0, 0, 0, 0, 0, 0, 6'h00, SWEEP_CAT, 1'b0));
        send_item(OP_CLEAR, random_fields());

        // Empty queue, empty category, probe with nothing active, unused modes
        send_item(OP_POP, make_item(0, 0, 0, 0, 0, 0, 6'h00, 8'h00, 1'b0));
        send_item(OP_ACTIVATE, make_item(0, 0, 0, 0, 0, 0, 6'h00, 8'h55, 1'b0));
        send_item(OP_PROBE, make_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF,
                                      6'h3F, 8'hFF, 1'b1));
        send_item(MODE_SPARE_A, make_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF,
                                          8'hFF, 6'h3F, 8'hFF, 1'b1));
        send_item(MODE_SPARE_B, make_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF,
                                          8'hFF, 6'h3F, SWEEP_CAT, 1'b1));

        // Exact rules at both extremes, one of them starting inactive
        send_item(OP_APPEND, make_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF,
                                       6'h00, 8'hFF, 1'b1));
        send_item(OP_APPEND, make_item(0, 0, 0, 0, 0, 0, 6'h00, 8'h00, 1'b0));
        send_item(OP_PROBE, make_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF,
                                      6'h00, 8'h00, 1'b0));
        send_item(OP_PROBE, make_item(0, 0, 0, 0, 0, 0, 6'h00, 8'h00, 1'b0));
        send_item(OP_ACTIVATE, make_item(0, 0, 0, 0, 0, 0, 6'h00, 8'h00, 1'b0));
        send_item(OP_PROBE, make_item(0, 0, 0, 0, 0, 0, 6'h00, 8'h00, 1'b0));
        send_item(OP_DEACTIVATE, make_item(0, 0, 0, 0, 0, 0, 6'h00, 8'hFF, 1'b0));

        // One wildcard bit per rule, then an exact probe and probes that miss in a single field
        base = make_item(16'h1234, 16'h5678, 16'h0110, 8'h0A, 8'h0B, 8'h0C,
                         6'h00, 8'h10, 1'b1);
        for (int b = 0; b < 6; b++)
        begin
            d = base;
            d.wildcard_mask = 6'(1 << b);
            send_item(OP_APPEND, d);
        end
        send_item(OP_PROBE, base);
        d = base;
        d.vendor_id = 16'hEDCB;
        send_item(OP_PROBE, d);
        d = base;
        d.protocol_code = 8'hF3;
        send_item(OP_PROBE, d);
        send_item(OP_POP, base);
        send_item(OP_POP, base);
        send_item(OP_CLEAR, base);
        send_item(OP_POP, base);

        for (int p = 0; p < PHASES; p++)
        begin
            drain(4);
            if (p == PHASES - 1)
                write_queue_size(9'($urandom_range(QSIZE_MIN, QSIZE_MAX)));
            else
                write_queue_size(size_plan[p]);
            case (p % 4)
                0:
                begin
                    send_gap_pct   = 0;
                    sink_stall_pct <= 0;
                end
                1:
                begin
                    send_gap_pct   = 72;
                    sink_stall_pct <= 0;
                end
                2:
                begin
                    send_gap_pct   = 0;
                    sink_stall_pct <= 72;
                end
                default:
                begin
                    send_gap_pct   = 32;
                    sink_stall_pct <= 32;
                end
            endcase

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n == ITEMS_PER_PHASE / 2)
                    drain(0);
                roll = $urandom_range(99);
                d    = random_fields();
                if (roll < 8)
                    mode = OP_APPEND;
                else if (roll < 16)
                    mode = OP_ACTIVATE;
                else if (roll < 24)
                    mode = OP_DEACTIVATE;
                else if (roll < 56)
                begin
                    mode = OP_PROBE;
                    d    = probe_fields();
                end
                else if (roll < 90)
                    mode = OP_POP;
                else if (roll < 95)
                    mode = OP_CLEAR;
                else
                    mode = roll[0] ? MODE_SPARE_A : MODE_SPARE_B;
                send_item(mode, d);
            end
        end

        drain(SETTLE_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
